// ----- rtl/monte_carlo_block_integrator_assert.svh -----
// Assertion macros for the Monte Carlo block integrator.
`ifndef MONTE_CARLO_BLOCK_INTEGRATOR_ASSERT_SVH
`define MONTE_CARLO_BLOCK_INTEGRATOR_ASSERT_SVH

// Immediate implication: when a holds, b holds in the same cycle.
`define MCBI_ASSERT_IMP(label, a, b) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (b)) \
    else $error("assertion failed");

// Next-cycle implication: when a holds, b holds in the next cycle.
`define MCBI_ASSERT_NXT(label, a, b) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (b)) \
    else $error("assertion failed");

`endif

// ----- rtl/mcbi_pkg.sv -----
package mcbi_pkg;
  localparam int SampleBitsDef = 16;
  localparam int FracBitsDef   = 30;
  localparam int CountBitsDef  = 16;
  localparam int WorkFrac      = 30;
  localparam int AccBits       = 48;
  localparam int OutBits       = 32;
  localparam int QueueDepth    = 2;
  localparam logic [WorkFrac+1:0] HalfPiQ30 = 32'd1686629713;
  localparam logic [15:0] BlockLenReset = 16'd100;

  localparam logic [0:0] RegMode = 1'd0;
  localparam logic [0:0] RegLen  = 1'd1;

  // Reciprocal form of one series divisor: shift right by pre, multiply by
  // mul, shift right by post.
  typedef struct packed {
    logic [31:0] mul;
    logic [1:0]  pre;
    logic [5:0]  post;
  } recip_t;

  // Series divisors of sin(t)/t, innermost term first. The power-of-two
  // factor of each divisor is shifted out first; the odd part then divides
  // a numerator below 2^31 exactly by a rounded-up reciprocal.
  function automatic recip_t series_recip(input logic [2:0] idx);
    recip_t r;
    unique case (idx)
      3'd0: r = '{mul: 32'((64'd1 << 38) / 64'd105 + 64'd1), pre: 2'd1, post: 6'd38};
      3'd1: r = '{mul: 32'((64'd1 << 37) / 64'd39 + 64'd1), pre: 2'd2, post: 6'd37};
      3'd2: r = '{mul: 32'((64'd1 << 37) / 64'd55 + 64'd1), pre: 2'd1, post: 6'd37};
      3'd3: r = '{mul: 32'((64'd1 << 35) / 64'd9 + 64'd1), pre: 2'd3, post: 6'd35};
      3'd4: r = '{mul: 32'((64'd1 << 36) / 64'd21 + 64'd1), pre: 2'd1, post: 6'd36};
      3'd5: r = '{mul: 32'((64'd1 << 34) / 64'd5 + 64'd1), pre: 2'd2, post: 6'd34};
      default: r = '{mul: 32'((64'd1 << 33) / 64'd3 + 64'd1), pre: 2'd1, post: 6'd33};
    endcase
    return r;
  endfunction

  // Control handed from the front end to the back end with each value.
  typedef struct packed {
    logic        last;
    logic [15:0] count;
  } blk_ctl_t;
endpackage

// ----- rtl/mcbi_divider.sv -----
// Restoring divider, one quotient bit per cycle. Quotient is floored.
module mcbi_divider #(
  parameter int NumBits = 64,
  parameter int DenBits = 48
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [NumBits-1:0] num_i,
  input  logic [DenBits-1:0] den_i,
  output logic               done_o,
  output logic [NumBits-1:0] quot_o
);
  localparam int CntBits = $clog2(NumBits + 1);
  logic [NumBits-1:0] quot_q, quot_d;
  logic [DenBits:0]   rem_q, rem_d;
  logic [DenBits-1:0] den_q, den_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d, done_q, done_d;
  logic [DenBits:0]   trial;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[DenBits-1:0], quot_q[NumBits-1]};
    if (start_i) begin
      quot_d = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = CntBits'(NumBits);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quot_d = {quot_q[NumBits-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quot_d = {quot_q[NumBits-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntBits'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
endmodule

// ----- rtl/mcbi_front.sv -----
// Front end: evaluates the integrand for one sample with a sequencer and
// tags it with the block position. Each series divide is a reciprocal
// multiply on the shared multiplier.
module mcbi_front #(
  parameter int SampleBits = mcbi_pkg::SampleBitsDef,
  parameter int FracBits   = mcbi_pkg::FracBitsDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  logic [SampleBits-1:0]   sample_i,
  output logic                    busy_o,
  input  logic                    mode_i,
  input  logic [15:0]             block_len_i,
  output logic                    out_valid_o,
  output logic [mcbi_pkg::AccBits-1:0] out_value_o,
  output mcbi_pkg::blk_ctl_t      out_ctl_o,
  input  logic                    out_ready_i
);
  localparam int W = mcbi_pkg::WorkFrac;
  localparam logic [2:0] S_IDLE = 3'd0, S_T = 3'd1, S_S = 3'd2, S_SER = 3'd3,
                         S_SDIV = 3'd4, S_F1 = 3'd5, S_F2 = 3'd6, S_OUT = 3'd7;
  logic [2:0]  st_q, st_d;
  logic [W:0]  v_q, v_d, t_q, t_d, h_q, h_d;
  logic [W+1:0] s_q, s_d, p_q, p_d;
  logic [2:0]  idx_q, idx_d;
  logic [15:0] cnt_q, cnt_d;
  logic        last_q, last_d;
  logic [2*W+3:0] prod;
  logic [W+1:0] ma, mb;
  mcbi_pkg::recip_t rc;
  logic [16:0] nxt;
  logic [W+1:0] fshift;

  always_comb begin
    rc = mcbi_pkg::series_recip(idx_q);
    unique case (st_q)
      S_T:    begin ma = mcbi_pkg::HalfPiQ30; mb = {1'b0, v_q}; end
      S_S:    begin ma = {1'b0, t_q}; mb = {1'b0, t_q}; end
      S_SER:  begin ma = s_q; mb = {1'b0, h_q}; end
      S_SDIV: begin ma = (W+2)'(rc.mul); mb = p_q >> rc.pre; end
      S_F1:   begin
        ma = mode_i ? mcbi_pkg::HalfPiQ30 : {1'b0, t_q}; mb = {1'b0, h_q};
      end
      S_F2:   begin ma = mcbi_pkg::HalfPiQ30; mb = p_q; end
      default: begin ma = {1'b0, t_q}; mb = {1'b0, t_q}; end
    endcase
    prod = (2*W+4)'(ma) * (2*W+4)'(mb);
  end

  always_comb begin
    if (FracBits >= W) fshift = p_q;
    else fshift = p_q >> (W - FracBits);
  end

  always_comb begin
    st_d = st_q; v_d = v_q; t_d = t_q; s_d = s_q; h_d = h_q; p_d = p_q;
    idx_d = idx_q; cnt_d = cnt_q; last_d = last_q;
    nxt = {1'b0, cnt_q} + 17'd1;
    unique case (st_q)
      S_IDLE: if (push_i) begin
        v_d = (W+1)'((((SampleBits+W+1)'(1) << (SampleBits+W))
               - ((SampleBits+W+1)'(sample_i) << W)) >> SampleBits);
        st_d = S_T;
      end
      S_T: begin t_d = prod[2*W:W]; st_d = S_S; end
      S_S: begin
        s_d = prod[2*W+1:W]; h_d = (W+1)'(1) << W; idx_d = '0; st_d = S_SER;
      end
      S_SER: begin p_d = prod[2*W+1:W]; st_d = S_SDIV; end
      S_SDIV: begin
        h_d = ((W+1)'(1) << W) - (W+1)'(prod >> rc.post);
        if (idx_q == 3'd6) st_d = S_F1;
        else begin idx_d = idx_q + 3'd1; st_d = S_SER; end
      end
      S_F1: begin p_d = prod[2*W+1:W]; st_d = S_F2; end
      S_F2: begin
        p_d = mode_i ? {1'b0, prod[2*W+1:W+1]} : prod[2*W+1:W];
        st_d = S_OUT;
        if ({1'b0, nxt[15:0]} >= {1'b0, block_len_i} || nxt[16]) begin
          last_d = 1'b1; cnt_d = nxt[15:0];
        end else begin
          last_d = 1'b0; cnt_d = nxt[15:0];
        end
      end
      default: if (out_ready_i) begin
        st_d = S_IDLE;
        if (last_q) cnt_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; cnt_q <= '0; idx_q <= '0; last_q <= 1'b0;
    end else begin
      st_q <= st_d; cnt_q <= cnt_d; idx_q <= idx_d; last_q <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d; t_q <= t_d; s_q <= s_d; h_q <= h_d; p_q <= p_d;
  end

  assign busy_o      = (st_q != S_IDLE);
  assign out_valid_o = (st_q == S_OUT);
  assign out_value_o = mcbi_pkg::AccBits'(fshift) << ((FracBits > W) ? FracBits - W : 0);
  assign out_ctl_o.last  = last_q;
  assign out_ctl_o.count = cnt_q;
endmodule

// ----- rtl/mcbi_queue.sv -----
// Small queue of values between the front and back ends.
module mcbi_queue #(
  parameter int Width = 64,
  parameter int Depth = mcbi_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             rd_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);
  localparam int PtrBits = (Depth > 1) ? $clog2(Depth) : 1;
  logic [Width-1:0]   mem_q [Depth];
  logic [PtrBits-1:0] wp_q, rp_q;
  logic [PtrBits:0]   cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (wr_i && !full_o) wp_q <= (wp_q == PtrBits'(Depth-1)) ? '0 : wp_q + 1'b1;
      if (rd_i && !empty_o) rp_q <= (rp_q == PtrBits'(Depth-1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (PtrBits+1)'(wr_i && !full_o) - (PtrBits+1)'(rd_i && !empty_o);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i && !full_o) mem_q[wp_q] <= wdata_i;
  end

  assign full_o  = (cnt_q == (PtrBits+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rp_q];
endmodule

// ----- rtl/mcbi_sqrt.sv -----
// Bit-pair square root, one result bit per cycle, floored.
module mcbi_sqrt #(
  parameter int Bits = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [Bits-1:0] x_i,
  output logic            done_o,
  output logic [Bits/2-1:0] root_o
);
  localparam int H = Bits / 2;
  localparam int CntBits = $clog2(H + 1);
  logic [Bits-1:0]  x_q;
  logic [H+1:0]     rem_q;
  logic [H-1:0]     r_q;
  logic [CntBits-1:0] cnt_q;
  logic             busy_q, done_q;
  logic [H+1:0]     trial, cand;

  always_comb begin
    trial = {rem_q[H-1:0], x_q[Bits-1:Bits-2]};
    cand  = {r_q, 2'b01};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1; cnt_q <= CntBits'(H);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntBits'(1)) begin busy_q <= 1'b0; done_q <= 1'b1; end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= x_i; rem_q <= '0; r_q <= '0;
    end else if (busy_q) begin
      x_q <= x_q << 2;
      if (trial >= cand) begin
        rem_q <= trial - cand; r_q <= {r_q[H-2:0], 1'b1};
      end else begin
        rem_q <= trial; r_q <= {r_q[H-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign root_o = r_q;
endmodule

// ----- rtl/mcbi_back.sv -----
// Back end: accumulates values into blocks and forms block statistics.
module mcbi_back #(
  parameter int FracBits  = mcbi_pkg::FracBitsDef,
  parameter int CountBits = mcbi_pkg::CountBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic [mcbi_pkg::AccBits-1:0] in_value_i,
  input  mcbi_pkg::blk_ctl_t           in_ctl_i,
  output logic                         in_ready_o,
  output logic                         res_valid_o,
  input  logic                         res_ready_i,
  output logic [CountBits-1:0]         block_number_o,
  output logic [31:0]                  running_mean_o,
  output logic [31:0]                  running_mean_square_o,
  output logic [31:0]                  statistical_error_o
);
  localparam int A = mcbi_pkg::AccBits;
  localparam int D = 64;
  localparam logic [3:0] B_IDLE = 4'd0, B_MDIV = 4'd1, B_MSQ = 4'd2, B_CM = 4'd3,
    B_CMW = 4'd4, B_CS = 4'd5, B_CSW = 4'd6, B_M2 = 4'd7, B_VAR = 4'd8,
    B_VW = 4'd9, B_SQ = 4'd10, B_SQW = 4'd11, B_OUT = 4'd12;
  logic [3:0]  st_q;
  logic [A-1:0] acc_q, som_q, sos_q;
  logic [CountBits-1:0] k_q;
  logic [A-1:0] mean_q, cm_q, cs_q;
  logic [31:0]  err_q;
  logic        dstart, ddone, sstart, sdone;
  logic [D-1:0] dnum, dquot;
  logic [A-1:0] dden;
  logic [D-1:0] sx;
  logic [31:0]  sroot;
  logic [31:0]  sq_in;
  logic [63:0]  sq;
  logic [A-1:0] sqr;

  // Squares a block mean or the running mean in Q2.30; every mean stays below 2^31.
  always_comb begin
    sq  = 64'(sq_in) * 64'(sq_in);
    sqr = A'((sq + (64'd1 << (FracBits - 1))) >> FracBits);
  end

  mcbi_divider #(.NumBits(D), .DenBits(A)) u_div (
    .clk_i, .rst_ni, .start_i(dstart), .num_i(dnum), .den_i(dden),
    .done_o(ddone), .quot_o(dquot));

  mcbi_sqrt #(.Bits(D)) u_sqrt (
    .clk_i, .rst_ni, .start_i(sstart), .x_i(sx), .done_o(sdone), .root_o(sroot));

  always_comb begin
    dstart = 1'b0; dnum = '0; dden = '1; sstart = 1'b0; sx = '0; sq_in = mean_q[31:0];
    unique case (st_q)
      B_IDLE: begin
        dnum = D'(acc_q + in_value_i) + D'(in_ctl_i.count >> 1);
        dden = A'(in_ctl_i.count);
        dstart = in_valid_i && in_ctl_i.last;
      end
      B_CM: begin
        dnum = D'(som_q) + D'(k_q >> 1); dden = A'(k_q); dstart = 1'b1;
      end
      B_CS: begin
        dnum = D'(sos_q) + D'(k_q >> 1); dden = A'(k_q); dstart = 1'b1;
      end
      B_M2: sq_in = cm_q[31:0];
      B_VAR: begin
        sq_in = cm_q[31:0];
        dnum = D'((cs_q > sqr) ? cs_q - sqr : '0) + D'((k_q - 1'b1) >> 1);
        dden = A'(k_q - 1'b1); dstart = 1'b1;
      end
      B_SQ: begin sx = dquot << FracBits; sstart = 1'b1; end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= B_IDLE; acc_q <= '0; som_q <= '0; sos_q <= '0; k_q <= '0;
    end else begin
      unique case (st_q)
        B_IDLE: if (in_valid_i) begin
          if (in_ctl_i.last) begin acc_q <= '0; st_q <= B_MDIV; end
          else acc_q <= acc_q + in_value_i;
        end
        B_MDIV: if (ddone) begin
          mean_q <= dquot[A-1:0]; st_q <= B_MSQ;
        end
        B_MSQ: begin
          if (k_q == '1) begin
            som_q <= mean_q; sos_q <= sqr; k_q <= CountBits'(1);
          end else begin
            som_q <= som_q + mean_q; sos_q <= sos_q + sqr; k_q <= k_q + 1'b1;
          end
          st_q <= B_CM;
        end
        B_CM: st_q <= B_CMW;
        B_CMW: if (ddone) begin cm_q <= dquot[A-1:0]; st_q <= B_CS; end
        B_CS: st_q <= B_CSW;
        B_CSW: if (ddone) begin
          cs_q <= dquot[A-1:0];
          if (k_q == CountBits'(1)) begin err_q <= '0; st_q <= B_OUT; end
          else st_q <= B_M2;
        end
        B_M2: st_q <= B_VAR;
        B_VAR: st_q <= B_VW;
        B_VW: if (ddone) st_q <= B_SQ;
        B_SQ: st_q <= B_SQW;
        B_SQW: if (sdone) begin err_q <= sroot; st_q <= B_OUT; end
        B_OUT: if (res_ready_i) st_q <= B_IDLE;
        default: st_q <= B_IDLE;
      endcase
    end
  end

  assign in_ready_o            = (st_q == B_IDLE);
  assign res_valid_o           = (st_q == B_OUT);
  assign block_number_o        = k_q;
  assign running_mean_o        = cm_q[31:0];
  assign running_mean_square_o = cs_q[31:0];
  assign statistical_error_o   = err_q;
endmodule

// ----- rtl/monte_carlo_block_integrator.sv -----
// A sample goes through the integrand sequencer and the queue to the back end,
// which at a block end forms the block statistics (the error only after the
// first block) before offering the result; a sample inside a block is summed
// as it leaves the queue. The sequencer takes a new sample once the last is
// handed on; block ends outpacing the back end fill the queue and stall input.
// Reset: rst_ni clears all control state and sums asynchronously; registers
// return to mode 0 and block length 100.
module monte_carlo_block_integrator #(
  parameter int SampleBits = mcbi_pkg::SampleBitsDef,
  parameter int FracBits   = mcbi_pkg::FracBitsDef,
  parameter int CountBits  = mcbi_pkg::CountBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  logic [SampleBits-1:0] sample_i,
  output logic                  empty,
  input  logic                  pop,
  output logic [CountBits-1:0]  block_number_o,
  output logic [31:0]           running_mean_o,
  output logic [31:0]           running_mean_square_o,
  output logic [31:0]           statistical_error_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  localparam int QW = mcbi_pkg::AccBits + 17;
  logic        mode_q;
  logic [15:0] len_q;
  logic        fbusy, fvalid, qfull, qempty, bready;
  logic [mcbi_pkg::AccBits-1:0] fvalue;
  mcbi_pkg::blk_ctl_t fctl, qctl;
  logic [QW-1:0] qdata;

  // Register file: a transaction writes on the access phase.
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      len_q  <= mcbi_pkg::BlockLenReset;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == mcbi_pkg::RegMode) mode_q <= pwdata[0];
      else len_q <= pwdata[15:0];
    end
  end
  assign prdata = (paddr[2] == mcbi_pkg::RegMode) ? {31'd0, mode_q} : {16'd0, len_q};

  // A zero block length acts as one, which the >= compare already gives.
  assign full = fbusy;

  mcbi_front #(.SampleBits(SampleBits), .FracBits(FracBits)) u_front (
    .clk_i, .rst_ni, .push_i(push), .sample_i, .busy_o(fbusy), .mode_i(mode_q),
    .block_len_i(len_q), .out_valid_o(fvalid), .out_value_o(fvalue),
    .out_ctl_o(fctl), .out_ready_i(!qfull));

  mcbi_queue #(.Width(QW)) u_queue (
    .clk_i, .rst_ni, .wr_i(fvalid), .wdata_i({fctl, fvalue}), .full_o(qfull),
    .rd_i(bready), .rdata_o(qdata), .empty_o(qempty));

  assign qctl = qdata[QW-1:mcbi_pkg::AccBits];

  logic bvalid;
  mcbi_back #(.FracBits(FracBits), .CountBits(CountBits)) u_back (
    .clk_i, .rst_ni, .in_valid_i(!qempty), .in_value_i(qdata[mcbi_pkg::AccBits-1:0]),
    .in_ctl_i(qctl), .in_ready_o(bready), .res_valid_o(bvalid), .res_ready_i(pop),
    .block_number_o, .running_mean_o, .running_mean_square_o, .statistical_error_o);

  assign empty = !bvalid;

`include "monte_carlo_block_integrator_assert.svh"
  `MCBI_ASSERT_IMP(a_full_when_busy, push && !full, 1'b1)
  `MCBI_ASSERT_NXT(a_push_makes_busy, push && !full, full)
  `MCBI_ASSERT_IMP(a_nonzero_block, !empty, block_number_o != '0)
endmodule

// ----- bench/monte_carlo_block_integrator_tb.sv -----
module monte_carlo_block_integrator_tb;

  // One completed block as reported on the result ports.
  typedef struct {
    logic [15:0] blk;
    logic [31:0] mean;
    logic [31:0] mean_sq;
    logic [31:0] err;
  } block_stats_t;

  localparam int  SettleCycles = 400;     // sample latency plus block-end work
  localparam int  LongHold     = 3000;
  localparam longint CycleLimit = 3000000;
  localparam longint unsigned One30 = 64'd1 << 30;
  localparam longint unsigned Mask48 = (64'd1 << 48) - 1;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [15:0] sample_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [15:0] block_number_o;
  logic [31:0] running_mean_o;
  logic [31:0] running_mean_square_o;
  logic [31:0] statistical_error_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  monte_carlo_block_integrator dut (.*);

  always #10 clk_i = ~clk_i;

  // Samples waiting to be offered, and block statistics waiting to be seen.
  logic [15:0]  sample_q[$];
  block_stats_t stats_q[$];
  int           mismatches = 0;
  bit           failed = 1'b0;

  // Mirror of the configuration and of the integrator state.
  logic        mode_r = 1'b0;
  logic [15:0] len_r = mcbi_pkg::BlockLenReset;
  longint unsigned blk_count, blk_sum, blocks_seen, mean_sum, mean_sq_sum;

  function automatic longint unsigned round_half_up(longint unsigned x, longint unsigned n);
    return (x + n / 2) / n;
  endfunction

  function automatic longint unsigned frac_square(longint unsigned m);
    return (m * m + (64'd1 << 29)) >> 30;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Cosine integrand (scaled sin(t)/t in mode 1) from a truncated sin(t)/t series, t = pi/2 * (1-u).
  function automatic longint unsigned integrand_value(logic [15:0] u, logic mode);
    longint unsigned v, t, s, h, a;
    int divs[7];
    divs = '{210, 156, 110, 72, 42, 20, 6};
    a = 64'd1686629713;
    v = ((64'd65536 - u) << 30) >> 16;
    t = (a * v) >> 30;
    s = (t * t) >> 30;
    h = One30;
    for (int i = 0; i < 7; i++) h = One30 - (((s * h) >> 30) / divs[i]);
    if (mode) return (a * ((a * h) >> 30)) >> 31;
    return (a * ((t * h) >> 30)) >> 30;
  endfunction

  // Adds one sample; at a block end queues the new cumulative statistics.
  function automatic void accumulate_sample(logic [15:0] u);
    longint unsigned n, mean, cm, cs, m2, dev;
    block_stats_t r;
    blk_sum = (blk_sum + integrand_value(u, mode_r)) & Mask48;
    n = blk_count + 1;
    if (n < len_r) begin
      blk_count = n;
      return;
    end
    mean = round_half_up(blk_sum, n);
    blk_sum = 0;
    blk_count = 0;
    // A full block counter restarts the statistics.
    if (blocks_seen >= 65535) begin
      blocks_seen = 0;
      mean_sum = 0;
      mean_sq_sum = 0;
    end
    mean_sum = (mean_sum + mean) & Mask48;
    mean_sq_sum = (mean_sq_sum + frac_square(mean)) & Mask48;
    blocks_seen++;
    cm = round_half_up(mean_sum, blocks_seen);
    cs = round_half_up(mean_sq_sum, blocks_seen);
    r.err = '0;
    if (blocks_seen > 1) begin
      m2 = frac_square(cm);
      // Rounding can push the variance below zero; it is clamped.
      dev = (cs > m2) ? cs - m2 : 0;
      r.err = floor_sqrt(round_half_up(dev, blocks_seen - 1) << 30);
    end
    r.blk = blocks_seen[15:0];
    r.mean = cm[31:0];
    r.mean_sq = cs[31:0];
    stats_q.push_back(r);
  endfunction

  // The driver offers samples in bursts separated by random gaps. Each
  // accepted transaction goes straight into the predictor.
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      if (push && !full) accumulate_sample(sample_i);
      if (!(push && full)) begin
        if (gap_left > 0) begin
          gap_left--;
          push <= 1'b0;
        end else if (sample_q.size() > 0) begin
          sample_i <= sample_q.pop_front();
          push <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 20);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 150);
          end
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold, requested by the stimulus and counted down here.
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;

  always @(posedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = LongHold;
    end else if (hold_left > 0) begin
      hold_left--;
    end
  end

  // The monitor checks each popped transaction against the oldest expected
  // block result, and varies its own pop pattern over time.
  int stall_style = 0;
  int style_left = 0;

  always @(posedge clk_i) begin
    block_stats_t x;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (stats_q.size() == 0) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result: block %0d", block_number_o);
        end else begin
          x = stats_q.pop_front();
          if (x.blk !== block_number_o || x.mean !== running_mean_o ||
              x.mean_sq !== running_mean_square_o || x.err !== statistical_error_o) begin
            failed = 1'b1;
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch: expected blk %0d mean %h msq %h err %h, got %0d %h %h %h",
                       x.blk, x.mean, x.mean_sq, x.err, block_number_o, running_mean_o,
                       running_mean_square_o, statistical_error_o);
          end
        end
      end
      if (style_left == 0) begin
        stall_style = $urandom_range(0, 2);
        style_left = $urandom_range(100, 2000);
      end else begin
        style_left--;
      end
      if (hold_left > 0) pop <= 1'b0;
      else if (stall_style == 0) pop <= 1'b1;
      else if (stall_style == 1) pop <= ($urandom_range(0, 1) == 1);
      else pop <= ($urandom_range(0, 9) == 0);
    end
  end

  // Run limit.
  longint cycles = 0;
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic reg_write(logic [2:0] addr, logic [31:0] data);
    @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == 3'(mcbi_pkg::RegMode) * 3'd4) mode_r = data[0];
    else len_r = data[15:0];
  endtask

  // Waits for every sample to be accepted and every result to be seen, then
  // lets the block finish any partial work.
  task automatic drain();
    while (sample_q.size() > 0 || push || stats_q.size() > 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic configure(logic mode, logic [15:0] len);
    reg_write(3'(mcbi_pkg::RegMode) * 3'd4, {31'd0, mode});
    reg_write(3'(mcbi_pkg::RegLen) * 3'd4, {16'd0, len});
  endtask

  int sent = 0;

  initial begin
    blk_count = 0; blk_sum = 0; blocks_seen = 0; mean_sum = 0; mean_sq_sum = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset configuration: plain cosine, blocks of 100, with field extremes.
    sample_q = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'h5555, 16'hAAAA};
    while (sample_q.size() < 100) sample_q.push_back(16'($urandom_range(0, 65535)));
    sent += 100;
    drain();

    // Length zero acts as one; the divided integrand at both ends.
    configure(1'b1, 16'd0);
    sample_q = '{16'h0000, 16'hFFFF, 16'h0001, 16'hFFFE, 16'h8000};
    sent += 5;
    drain();

    // Identical samples give equal block means, where rounding can make the
    // variance negative.
    configure(1'b0, 16'd1);
    repeat (8) sample_q.push_back(16'h3A7C);
    sent += 8;
    drain();

    // Longest block, then shrunk mid-block: the next sample closes it.
    configure(1'b1, 16'hFFFF);
    repeat (5) sample_q.push_back(16'($urandom_range(0, 65535)));
    drain();
    reg_write(3'(mcbi_pkg::RegLen) * 3'd4, 32'd1);
    sample_q.push_back(16'hFFFF);
    sent += 6;
    drain();

    // Receiver held off while the sender keeps offering.
    configure(1'b0, 16'd1);
    repeat (60) sample_q.push_back(16'($urandom_range(0, 65535)));
    sent += 60;
    hold_req++;
    drain();

    while (sent < 1650) begin
      int n;
      logic [15:0] len;
      n = $urandom_range(20, 80);
      len = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(9, 40))
                                        : 16'($urandom_range(0, 8));
      configure(1'($urandom_range(0, 1)), len);
      repeat (n) sample_q.push_back(16'($urandom_range(0, 65535)));
      sent += n;
      drain();
    end

    if (stats_q.size() != 0) failed = 1'b1;
    if (!failed) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
